// ===== hdl/ats_pkg.sv =====
// Shared types, codes and helpers for the alarm table with snooze.
package ats_pkg;

   localparam int CAPACITY_DEF       = 6;
   localparam int MAX_SNOOZES_DEF    = 11;
   localparam int SNOOZE_MINUTES_DEF = 1;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_SNOOZE = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   localparam logic [2:0] EV_NOTHING   = 3'd0;
   localparam logic [2:0] EV_FIRED     = 3'd1;
   localparam logic [2:0] EV_STORED    = 3'd2;
   localparam logic [2:0] EV_FULL      = 3'd3;
   localparam logic [2:0] EV_REMOVED   = 3'd4;
   localparam logic [2:0] EV_STOPPED   = 3'd5;
   localparam logic [2:0] EV_SNOOZED   = 3'd6;
   localparam logic [2:0] EV_EXHAUSTED = 3'd7;

   localparam logic [1:0] KIND_DAILY  = 2'd0;
   localparam logic [1:0] KIND_WEEKLY = 2'd1;
   localparam logic [1:0] KIND_ONCE   = 2'd2;

   localparam logic [1:0] BL_LEAVE = 2'd0;
   localparam logic [1:0] BL_ON    = 2'd1;
   localparam logic [1:0] BL_OFF   = 2'd2;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [3:0]  hour;
      logic [5:0]  minute;
      logic        pm;
      logic [2:0]  weekday;
      logic [7:0]  station;
      logic [1:0]  kind;
      logic [3:0]  snz;
   } alarm_rec_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] play_station;
      logic [1:0] fired_kind;
      logic [1:0] backlight;
      logic       last;
   } result_type;

   function automatic logic same_alarm(input alarm_rec_type key, input alarm_rec_type e);
      logic t;
      t = key.hour == e.hour && key.minute == e.minute && key.pm == e.pm;
      if (key.kind == KIND_WEEKLY) begin
         same_alarm = t && key.weekday == e.weekday;
      end else begin
         same_alarm = t && key.year == e.year && key.month == e.month &&
                      key.day == e.day && key.kind == e.kind;
      end
   endfunction

   function automatic logic fires(input alarm_rec_type now, input alarm_rec_type e);
      logic t;
      t = e.hour == now.hour && e.minute == now.minute && e.pm == now.pm;
      case (e.kind)
         KIND_DAILY:  fires = t;
         KIND_WEEKLY: fires = t && e.weekday == now.weekday;
         KIND_ONCE:   fires = t && e.day == now.day && e.month == now.month &&
                              e.year == now.year;
         default:     fires = 1'b0;
      endcase
   endfunction

endpackage

// ===== hdl/ats_req_if.sv =====
// Request channel: valid/ready plus one request word.
interface ats_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [1:0]  kind;
   logic [13:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [3:0]  hour;
   logic [5:0]  minute;
   logic        pm;
   logic [2:0]  weekday;
   logic [7:0]  station;
   logic [3:0]  snooze_count;

   modport source (output valid, op, kind, year, month, day, hour, minute, pm, weekday,
                   station, snooze_count, input ready);
   modport sink (input valid, op, kind, year, month, day, hour, minute, pm, weekday,
                 station, snooze_count, output ready);
endinterface

// Response channel: valid/ready plus one response word.
interface ats_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] play_station;
   logic [1:0] fired_kind;
   logic [1:0] backlight;
   logic       last;

   modport source (output valid, event_res, play_station, fired_kind, backlight, last,
                   input ready);
   modport sink (input valid, event_res, play_station, fired_kind, backlight, last,
                 output ready);
endinterface

// ===== hdl/ats_mem.sv =====
// Alarm entry memory: one write port, one registered read port.
module ats_mem #(
   parameter int DEPTH = ats_pkg::CAPACITY_DEF,
   parameter int AW    = 3
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  ats_pkg::alarm_rec_type wdata,
   input  logic                   re,
   input  logic [AW-1:0]          raddr,
   output ats_pkg::alarm_rec_type rdata
);

   ats_pkg::alarm_rec_type mem [DEPTH];
   ats_pkg::alarm_rec_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/alarm_table_with_snooze_core.sv =====
// Alarm table with snooze: request sequencer around the entry memory.
//
// req_chan takes one request word per accept (valid & ready). ready is high
// only while the sequencer is idle; one request is worked on at a time.
// rsp_chan returns one or more response words per request; last marks the
// final one. Tick fires every matching alarm in table order, one word each.
// Add, clear and snooze/stop without a table walk go from idle straight to
// the done state, which loads the response. Tick, remove and snooze/stop
// with a nonzero count walk the table entry by entry (memory read, then
// evaluate and write back compacted) before the done state.
// Responses sit in an output register, with one further word held while a
// tick scan goes on; a stalled receiver stops the scan until the word is
// taken. Reset empties the table and clears the active alarm; no clearing
// pass is needed since only entries below the count are read.
module alarm_table_with_snooze_core #(
   parameter int CAPACITY       = ats_pkg::CAPACITY_DEF,
   parameter int MAX_SNOOZES    = ats_pkg::MAX_SNOOZES_DEF,
   parameter int SNOOZE_MINUTES = ats_pkg::SNOOZE_MINUTES_DEF
) (
   input logic      clock,
   input logic      reset,
   ats_req_if.sink  req_chan,
   ats_rsp_if.source rsp_chan
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, r_ff, r_in, w_ff, w_in;
   ats_pkg::alarm_rec_type key_ff, key_in, act_ff, act_in;
   logic act_v_ff, act_v_in;
   logic tick_ff, tick_in, rmop_ff, rmop_in, first_ff, first_in;
   logic pend_v_ff, pend_v_in, out_v_ff, out_v_in;
   ats_pkg::result_type pend_ff, pend_in, out_ff, out_in, res_ff, res_in;

   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   ats_pkg::alarm_rec_type mem_wdata, rdata, it, snz_e;

   logic [6:0] mi;
   logic [4:0] hr;
   logic       pv;
   logic       out_free, fire, match, del;

   ats_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   always_comb begin
      it.year    = req_chan.year;
      it.month   = req_chan.month;
      it.day     = req_chan.day;
      it.hour    = req_chan.hour;
      it.minute  = req_chan.minute;
      it.pm      = req_chan.pm;
      it.weekday = req_chan.weekday;
      it.station = req_chan.station;
      it.kind    = req_chan.kind;
      it.snz     = req_chan.snooze_count;
   end

   // snoozed copy of the active alarm
   always_comb begin
      mi = {1'b0, act_ff.minute} + 7'(SNOOZE_MINUTES);
      hr = {1'b0, act_ff.hour};
      pv = act_ff.pm;
      if (mi > 7'd59) begin
         hr = hr + 5'd1;
         if (hr > 5'd12) begin
            hr = hr - 5'd12;
            pv = ~pv;
         end
         mi = mi - 7'd60;
      end
      snz_e         = '0;
      snz_e.hour    = hr[3:0];
      snz_e.minute  = mi[5:0];
      snz_e.pm      = pv;
      snz_e.weekday = (act_ff.kind == ats_pkg::KIND_WEEKLY) ? act_ff.weekday : 3'd0;
      snz_e.station = act_ff.station;
      snz_e.kind    = act_ff.kind;
      snz_e.snz     = act_ff.snz + 4'd1;
   end

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign fire     = ats_pkg::fires(key_ff, rdata);
   assign match    = ats_pkg::same_alarm(key_ff, rdata);
   assign del      = tick_ff ? (fire && rdata.kind == ats_pkg::KIND_ONCE)
                             : (match && !first_ff);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      w_in      = w_ff;
      key_in    = key_ff;
      act_in    = act_ff;
      act_v_in  = act_v_ff;
      tick_in   = tick_ff;
      rmop_in   = rmop_ff;
      first_in  = first_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      out_v_in  = out_v_ff && !rsp_chan.ready;
      out_in    = out_ff;
      mem_we    = 1'b0;
      mem_waddr = cnt_ff[AW-1:0];
      mem_wdata = it;
      mem_re    = 1'b0;
      mem_raddr = r_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               res_in    = '{ats_pkg::EV_NOTHING, 8'd0, ats_pkg::KIND_DAILY,
                             ats_pkg::BL_LEAVE, 1'b1};
               tick_in   = req_chan.op == ats_pkg::OP_TICK;
               rmop_in   = req_chan.op == ats_pkg::OP_REMOVE;
               first_in  = 1'b0;
               pend_v_in = 1'b0;
               r_in      = '0;
               w_in      = '0;
               key_in    = it;
               state_in  = ST_DONE;
               case (req_chan.op)
                  ats_pkg::OP_TICK: begin
                     state_in = ST_READ;
                  end
                  ats_pkg::OP_ADD: begin
                     res_in.fired_kind = it.kind;
                     if (cnt_ff < CW'(CAPACITY)) begin
                        mem_we           = 1'b1;
                        cnt_in           = cnt_ff + CW'(1);
                        res_in.event_res = ats_pkg::EV_STORED;
                     end else begin
                        res_in.event_res = ats_pkg::EV_FULL;
                     end
                  end
                  ats_pkg::OP_REMOVE: begin
                     res_in.fired_kind = it.kind;
                     state_in = ST_READ;
                  end
                  ats_pkg::OP_SNOOZE, ats_pkg::OP_STOP: begin
                     if (act_v_ff && act_ff.kind <= ats_pkg::KIND_WEEKLY) begin
                        res_in.fired_kind = act_ff.kind;
                        res_in.backlight  = ats_pkg::BL_OFF;
                        res_in.event_res  = ats_pkg::EV_STOPPED;
                        if (req_chan.op == ats_pkg::OP_SNOOZE) begin
                           if (act_ff.snz < 4'(MAX_SNOOZES)) begin
                              if (cnt_ff < CW'(CAPACITY)) begin
                                 mem_we           = 1'b1;
                                 mem_wdata        = snz_e;
                                 cnt_in           = cnt_ff + CW'(1);
                                 res_in.event_res = ats_pkg::EV_SNOOZED;
                              end else begin
                                 res_in.event_res = ats_pkg::EV_FULL;
                              end
                           end else begin
                              res_in.event_res = ats_pkg::EV_EXHAUSTED;
                           end
                        end
                        act_v_in = 1'b0;
                        key_in   = act_ff;
                        if (act_ff.snz != 4'd0) begin
                           state_in = ST_READ;
                        end
                     end else begin
                        res_in.fired_kind = act_v_ff ? act_ff.kind : ats_pkg::KIND_DAILY;
                     end
                  end
                  ats_pkg::OP_CLEAR: begin
                     cnt_in           = '0;
                     res_in.event_res = ats_pkg::EV_REMOVED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (r_ff == cnt_ff) begin
               cnt_in   = w_ff;
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!(tick_ff && fire && pend_v_ff && !out_free)) begin
               if (tick_ff && fire) begin
                  if (pend_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = pend_ff;
                  end
                  pend_v_in = 1'b1;
                  pend_in   = '{ats_pkg::EV_FIRED, rdata.station, rdata.kind,
                               (rdata.kind == ats_pkg::KIND_ONCE) ? ats_pkg::BL_LEAVE
                                                                  : ats_pkg::BL_ON,
                               1'b0};
                  act_in    = rdata;
                  act_v_in  = 1'b1;
               end
               if (!tick_ff && match && r_ff == '0) begin
                  first_in = 1'b1;
               end
               if (rmop_ff && del) begin
                  res_in.event_res = ats_pkg::EV_REMOVED;
               end
               if (!del) begin
                  mem_we    = 1'b1;
                  mem_waddr = w_ff[AW-1:0];
                  mem_wdata = rdata;
                  w_in      = w_ff + CW'(1);
               end
               r_in     = r_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_v_in = 1'b1;
               if (tick_ff && pend_v_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = res_ff;
               end
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         act_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         r_ff      <= '0;
         w_ff      <= '0;
         tick_ff   <= 1'b0;
         rmop_ff   <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         act_v_ff  <= act_v_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         r_ff      <= r_in;
         w_ff      <= w_in;
         tick_ff   <= tick_in;
         rmop_ff   <= rmop_in;
         first_ff  <= first_in;
      end
      key_ff  <= key_in;
      act_ff  <= act_in;
      pend_ff <= pend_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.event_res    = out_ff.event_res;
   assign rsp_chan.play_station = out_ff.play_station;
   assign rsp_chan.fired_kind   = out_ff.fired_kind;
   assign rsp_chan.backlight    = out_ff.backlight;
   assign rsp_chan.last         = out_ff.last;

endmodule

// ===== tb/sv/alarm_table_with_snooze_core_tb.sv =====
// Testbench for the alarm table with snooze: directed and random requests, scoreboard check.
module alarm_table_with_snooze_core_tb;

   localparam int WATCHDOG_LIMIT = 4000;

   logic clock;
   logic reset;

   ats_req_if req_chan ();
   ats_rsp_if rsp_chan ();

   alarm_table_with_snooze_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   typedef struct {
      logic [2:0]             op;
      ats_pkg::alarm_rec_type a;
   } request_type;

   ats_pkg::alarm_rec_type table_q[$];
   ats_pkg::alarm_rec_type active_alarm;
   logic                   active_valid;
   ats_pkg::result_type    expected_q[$];

   int  mismatches;
   int  idle_cycles;
   bit  long_hold;
   bit  timed_out;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic logic alarm_eq(ats_pkg::alarm_rec_type key, ats_pkg::alarm_rec_type e);
      if (key.kind == ats_pkg::KIND_WEEKLY)
         return key.weekday == e.weekday && key.hour == e.hour &&
                key.minute == e.minute && key.pm == e.pm;
      return key.year == e.year && key.month == e.month && key.day == e.day &&
             key.hour == e.hour && key.minute == e.minute && key.pm == e.pm &&
             key.kind == e.kind;
   endfunction

   function automatic logic drop_matching(ats_pkg::alarm_rec_type key);
      logic gone;
      int   i;
      gone = 1'b0;
      i = 0;
      if (table_q.size() == 0) return 1'b0;
      if (alarm_eq(key, table_q[0])) begin
         table_q.delete(0);
         return 1'b1;
      end
      while (i < table_q.size()) begin
         if (alarm_eq(key, table_q[i])) begin
            table_q.delete(i);
            gone = 1'b1;
         end else begin
            i++;
         end
      end
      return gone;
   endfunction

   function automatic void push_word(logic [2:0] ev, logic [7:0] st, logic [1:0] kd,
                                     logic [1:0] bl);
      ats_pkg::result_type r;
      r.event_res = ev;
      r.play_station = st;
      r.fired_kind = kd;
      r.backlight = bl;
      r.last = 1'b0;
      expected_q.push_back(r);
   endfunction

   function automatic void predict_request(request_type rq);
      ats_pkg::alarm_rec_type it, e, a, s;
      logic       fire;
      int         i, n0;
      logic [2:0] ev;
      logic [6:0] mi;
      logic [4:0] hr;
      logic       p;
      it = rq.a;
      n0 = expected_q.size();
      case (rq.op)
         ats_pkg::OP_TICK: begin
            i = 0;
            while (i < table_q.size()) begin
               e = table_q[i];
               fire = 1'b0;
               if (e.hour == it.hour && e.minute == it.minute && e.pm == it.pm) begin
                  if (e.kind == ats_pkg::KIND_DAILY) fire = 1'b1;
                  else if (e.kind == ats_pkg::KIND_WEEKLY) fire = e.weekday == it.weekday;
                  else if (e.kind == ats_pkg::KIND_ONCE)
                     fire = e.day == it.day && e.month == it.month && e.year == it.year;
               end
               if (fire) begin
                  push_word(ats_pkg::EV_FIRED, e.station, e.kind,
                            e.kind == ats_pkg::KIND_ONCE ? ats_pkg::BL_LEAVE
                                                         : ats_pkg::BL_ON);
                  active_alarm = e;
                  active_valid = 1'b1;
                  if (e.kind == ats_pkg::KIND_ONCE) begin
                     table_q.delete(i);
                     continue;
                  end
               end
               i++;
            end
         end
         ats_pkg::OP_ADD: begin
            if (table_q.size() < ats_pkg::CAPACITY_DEF) begin
               table_q.push_back(it);
               push_word(ats_pkg::EV_STORED, 8'd0, it.kind, ats_pkg::BL_LEAVE);
            end else begin
               push_word(ats_pkg::EV_FULL, 8'd0, it.kind, ats_pkg::BL_LEAVE);
            end
         end
         ats_pkg::OP_REMOVE:
            push_word(drop_matching(it) ? ats_pkg::EV_REMOVED : ats_pkg::EV_NOTHING,
                      8'd0, it.kind, ats_pkg::BL_LEAVE);
         ats_pkg::OP_SNOOZE, ats_pkg::OP_STOP: begin
            if (active_valid && active_alarm.kind <= ats_pkg::KIND_WEEKLY) begin
               a = active_alarm;
               ev = ats_pkg::EV_STOPPED;
               if (rq.op == ats_pkg::OP_SNOOZE) begin
                  if (a.snz < ats_pkg::MAX_SNOOZES_DEF) begin
                     mi = {1'b0, a.minute} + 7'(ats_pkg::SNOOZE_MINUTES_DEF);
                     hr = {1'b0, a.hour};
                     p = a.pm;
                     if (mi > 7'd59) begin
                        hr = hr + 5'd1;
                        if (hr > 5'd12) begin
                           hr = hr - 5'd12;
                           p = ~p;
                        end
                        mi = mi - 7'd60;
                     end
                     s = '0;
                     s.hour = hr[3:0];
                     s.minute = mi[5:0];
                     s.pm = p;
                     s.weekday = a.kind == ats_pkg::KIND_WEEKLY ? a.weekday : 3'd0;
                     s.station = a.station;
                     s.kind = a.kind;
                     s.snz = a.snz + 4'd1;
                     if (table_q.size() < ats_pkg::CAPACITY_DEF) begin
                        table_q.push_back(s);
                        ev = ats_pkg::EV_SNOOZED;
                     end else begin
                        ev = ats_pkg::EV_FULL;
                     end
                  end else begin
                     ev = ats_pkg::EV_EXHAUSTED;
                  end
               end
               if (a.snz > 0) void'(drop_matching(a));
               active_valid = 1'b0;
               push_word(ev, 8'd0, a.kind, ats_pkg::BL_OFF);
            end else begin
               push_word(ats_pkg::EV_NOTHING, 8'd0,
                         active_valid ? active_alarm.kind : ats_pkg::KIND_DAILY,
                         ats_pkg::BL_LEAVE);
            end
         end
         ats_pkg::OP_CLEAR: begin
            table_q.delete();
            push_word(ats_pkg::EV_REMOVED, 8'd0, ats_pkg::KIND_DAILY, ats_pkg::BL_LEAVE);
         end
         default: ;
      endcase
      if (expected_q.size() == n0)
         push_word(ats_pkg::EV_NOTHING, 8'd0, ats_pkg::KIND_DAILY, ats_pkg::BL_LEAVE);
      expected_q[expected_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------- sender ----------------
   int burst_left;

   task automatic send_request(request_type rq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.op <= rq.op;
      req_chan.kind <= rq.a.kind;
      req_chan.year <= rq.a.year;
      req_chan.month <= rq.a.month;
      req_chan.day <= rq.a.day;
      req_chan.hour <= rq.a.hour;
      req_chan.minute <= rq.a.minute;
      req_chan.pm <= rq.a.pm;
      req_chan.weekday <= rq.a.weekday;
      req_chan.station <= rq.a.station;
      req_chan.snooze_count <= rq.a.snz;
      do @(posedge clock); while (!(req_chan.ready === 1'b1));
      predict_request(rq);
   endtask

   task automatic release_valid();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic request_type rand_req(logic [2:0] op);
      request_type rq;
      rq.op = op;
      rq.a.kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      rq.a.year = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(2020, 2022));
      rq.a.month = $urandom_range(0, 7) == 0 ? 4'($urandom) : 4'($urandom_range(1, 2));
      rq.a.day = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(1, 2));
      rq.a.hour = $urandom_range(0, 7) == 0 ? 4'($urandom) : 4'($urandom_range(11, 12));
      rq.a.minute = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(58, 59));
      rq.a.pm = 1'($urandom);
      rq.a.weekday = $urandom_range(0, 7) == 0 ? 3'($urandom) : 3'($urandom_range(0, 1));
      rq.a.station = 8'($urandom);
      rq.a.snz = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 1));
      return rq;
   endfunction

   function automatic request_type mk(logic [2:0] op, int kind, int yr, int mo, int dy,
                                      int hr, int mi, int p, int wd, int st, int snz);
      request_type rq;
      rq.op = op;
      rq.a.kind = 2'(kind); rq.a.year = 14'(yr); rq.a.month = 4'(mo); rq.a.day = 5'(dy);
      rq.a.hour = 4'(hr); rq.a.minute = 6'(mi); rq.a.pm = 1'(p); rq.a.weekday = 3'(wd);
      rq.a.station = 8'(st); rq.a.snz = 4'(snz);
      return rq;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      send_request(mk(ats_pkg::OP_STOP, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_REMOVE, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_DAILY, 0, 0, 0, 12, 59, 1, 0, 8'hFF, 0));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_WEEKLY, 0, 0, 0, 12, 59, 1, 6, 8'h01,
                      10));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_ONCE, 14'h3FFF, 4'hF, 5'h1F, 12, 59, 1,
                      7, 8'h80, 4'hF));
      send_request(mk(ats_pkg::OP_ADD, 2'd3, 14'd9999, 12, 31, 12, 59, 1, 0, 8'h55, 0));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_ONCE, 2021, 1, 1, 12, 59, 1, 0, 8'hAA,
                      0));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_DAILY, 0, 0, 0, 12, 59, 1, 0, 8'h33, 0));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_DAILY, 0, 0, 0, 1, 0, 0, 0, 8'h44, 0));
      send_request(mk(ats_pkg::OP_TICK, ats_pkg::KIND_DAILY, 14'h3FFF, 4'hF, 5'h1F, 12, 59,
                      1, 6, 0, 0));
      send_request(mk(ats_pkg::OP_TICK, ats_pkg::KIND_DAILY, 2021, 1, 1, 12, 59, 1, 7, 0, 0));
      send_request(mk(ats_pkg::OP_SNOOZE, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_TICK, ats_pkg::KIND_DAILY, 0, 0, 0, 12, 59, 1, 6, 0, 0));
      send_request(mk(ats_pkg::OP_SNOOZE, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_REMOVE, ats_pkg::KIND_WEEKLY, 5, 5, 5, 12, 59, 1, 6, 0, 0));
      send_request(mk(ats_pkg::OP_TICK, ats_pkg::KIND_DAILY, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_STOP, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(3'd6, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(3'd7, 2'd3, 14'h3FFF, 4'hF, 5'h1F, 4'hF, 6'h3F, 1, 7, 8'hFF, 4'hF));
      send_request(mk(ats_pkg::OP_ADD, ats_pkg::KIND_WEEKLY, 0, 0, 0, 4'hF, 6'h3F, 1, 3,
                      8'h12, 11));
      send_request(mk(ats_pkg::OP_TICK, ats_pkg::KIND_DAILY, 0, 0, 0, 4'hF, 6'h3F, 1, 3, 0,
                      0));
      send_request(mk(ats_pkg::OP_SNOOZE, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(mk(ats_pkg::OP_CLEAR, ats_pkg::KIND_DAILY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      release_valid();
   endtask

   task automatic test_random();
      request_type rq;
      int k, r;
      for (k = 0; k < 150; k++) begin
         r = $urandom_range(0, 99);
         if (r < 30) rq = rand_req(ats_pkg::OP_ADD);
         else if (r < 58) rq = rand_req(ats_pkg::OP_TICK);
         else if (r < 70) rq = rand_req(ats_pkg::OP_SNOOZE);
         else if (r < 78) rq = rand_req(ats_pkg::OP_STOP);
         else if (r < 92) rq = rand_req(ats_pkg::OP_REMOVE);
         else if (r < 96) rq = rand_req(ats_pkg::OP_CLEAR);
         else rq = rand_req(3'($urandom_range(6, 7)));
         if (k == 60) long_hold = 1'b1;
         send_request(rq);
      end
      release_valid();
   endtask

   task automatic test_long_stall();
      request_type rq;
      int k;
      for (k = 0; k < 6; k++) begin
         rq = rand_req(ats_pkg::OP_ADD);
         rq.a.kind = ats_pkg::KIND_DAILY; rq.a.hour = 4'd5; rq.a.minute = 6'd5;
         rq.a.pm = 1'b0;
         send_request(rq);
      end
      long_hold = 1'b1;
      rq.op = ats_pkg::OP_TICK;
      for (k = 0; k < 4; k++) send_request(rq);
      release_valid();
   endtask

   // ---------------- receiver ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0) || (($time / 640) % 3 == 0);
      end
   end

   initial begin
      wait (long_hold);
      forever begin
         wait (long_hold);
         repeat (200) @(posedge clock);
         long_hold = 1'b0;
      end
   end

   always @(posedge clock) begin
      ats_pkg::result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word ev=%0d", rsp_chan.event_res);
         end else begin
            want = expected_q.pop_front();
            if (rsp_chan.event_res !== want.event_res ||
                rsp_chan.play_station !== want.play_station ||
                rsp_chan.fired_kind !== want.fired_kind ||
                rsp_chan.backlight !== want.backlight || rsp_chan.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp ev=%0d st=%0d kind=%0d bl=%0d last=%0d,",
                           want.event_res, want.play_station, want.fired_kind,
                           want.backlight, want.last,
                           " got ev=%0d st=%0d kind=%0d bl=%0d last=%0d",
                           rsp_chan.event_res, rsp_chan.play_station, rsp_chan.fired_kind,
                           rsp_chan.backlight, rsp_chan.last);
            end
         end
      end
   end

   // watchdog: cycles with no accept on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("alarm_table_with_snooze_core_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      idle_cycles = 0;
      long_hold = 1'b0;
      timed_out = 1'b0;
      burst_left = 0;
      active_valid = 1'b0;
      active_alarm = '0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = ats_pkg::OP_TICK;
      req_chan.kind = ats_pkg::KIND_DAILY;
      req_chan.year = '0;
      req_chan.month = '0;
      req_chan.day = '0;
      req_chan.hour = '0;
      req_chan.minute = '0;
      req_chan.pm = 1'b0;
      req_chan.weekday = '0;
      req_chan.station = '0;
      req_chan.snooze_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_stall();
      test_random();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("alarm_table_with_snooze_core_tb OK");
      end else begin
         $display("alarm_table_with_snooze_core_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ats_pkg.sv
hdl/ats_req_if.sv
hdl/ats_mem.sv
hdl/alarm_table_with_snooze_core.sv
tb/sv/alarm_table_with_snooze_core_tb.sv
